// ===== rtl/sha_pkg.sv =====
// sha_pkg: shared types, constants and round functions for the sha-256 hasher
`timescale 1ns / 1ps
package sha_pkg;

	localparam int unsigned WordW   = 32;
	localparam int unsigned BlkWrds = 16;
	localparam int unsigned AddrW   = 4;
	localparam int unsigned CountW  = 61;

	typedef logic [WordW-1:0] word_t;

	// control sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_PAD   = 6'b000010,
		ST_PRIME = 6'b000100,
		ST_ROUND = 6'b001000,
		ST_ADD   = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	localparam logic [7:0] PadByte = 8'h80;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t big_sig0(input word_t x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic word_t sml_sig0(input word_t x);
		sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sml_sig1(input word_t x);
		sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		choose = (e & f) ^ (~e & g);
	endfunction

	function automatic word_t major(input word_t a, input word_t b, input word_t c);
		major = (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ===== rtl/sha_ram.sv =====
// sha_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module sha_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// sha256_stream_hasher: byte-stream sha-256 hasher with block ram and round sequencer
//
// usage:
//   input channel (in_valid/in_ready) takes one request per byte: data_byte,
//   byte_valid (byte belongs to the message) and end_of_message (final request).
//   output channel (out_valid/out_ready) delivers the digest as eight 32-bit
//   words, most significant first, word_index 0..7, last_word on word 7.
// timing:
//   message bytes are packed into words; each word is written into the block ram
//   when its fourth byte arrives. every 64th byte starts a compression (a ram
//   prime step, 64 rounds at one per cycle, a hash add step); in_ready is low
//   meanwhile.
//   an end request pads one byte per cycle up to the block end, with one or
//   two compressions, then presents the eight digest words.
//   no new request is taken until the last digest word is accepted.
// reset: arst_n clears the sequencer and counters and loads the initial hash.
// stall: a low out_ready holds the current digest word; nothing is lost.
module sha256_stream_hasher (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  byte_valid,
	input  logic                  end_of_message,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sha_pkg::word_t        digest_word,
	output logic [2:0]            word_index,
	output logic                  last_word
);
	import sha_pkg::*;

	state_t              state_q;
	logic [5:0]          pos_q;
	logic [CountW-1:0]   count_q;
	logic [23:0]         part_q;
	logic                first_q;
	logic                len_q;
	logic                pad_q;
	logic                done_q;
	logic [5:0]          rnd_q;
	logic [2:0]          idx_q;
	word_t               hash_q [8];
	word_t               var_q [8];
	word_t               win_q [BlkWrds];

	logic                in_acc;
	logic                out_acc;
	logic                feed;
	logic                len_now;
	logic [63:0]         bit_len;
	logic [7:0]          len_byte;
	logic [7:0]          feed_byte;
	logic                ram_we;
	logic [AddrW-1:0]    ram_raddr;
	word_t               ram_rdata;
	word_t               w_sched;
	word_t               w_t;
	word_t               t1;
	word_t               t2;

	assign in_ready  = (state_q == ST_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc   = out_valid && out_ready;

	// padding byte selection: marker, zero fill, then big-endian bit length
	assign bit_len   = {count_q, 3'b000};
	assign len_byte  = bit_len[(6'(7 - 32'(pos_q[2:0])) << 3) +: 8];
	assign len_now   = !first_q && (len_q || pos_q == 6'd56);
	assign feed      = (in_acc && byte_valid) || (state_q == ST_PAD);
	always_comb begin
		feed_byte = data_byte;
		if (state_q == ST_PAD) begin
			priority if (first_q) begin
				feed_byte = PadByte;
			end else if (len_now) begin
				feed_byte = len_byte;
			end else begin
				feed_byte = 8'h00;
			end
		end
	end

	// block ram: word written when its fourth byte arrives
	assign ram_we    = feed && (pos_q[1:0] == 2'b11);
	assign ram_raddr = (state_q == ST_ROUND) ? rnd_q[AddrW-1:0] + 1'b1 : '0;

	sha_ram #(.Width(WordW), .Depth(BlkWrds)) u_blk_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pos_q[5:2]),
		.wdata ({part_q, feed_byte}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// message schedule and round function
	assign w_sched = sml_sig1(win_q[14]) + win_q[9] + sml_sig0(win_q[1]) + win_q[0];
	assign w_t     = (rnd_q < 6'd16) ? ram_rdata : w_sched;
	assign t1      = var_q[7] + big_sig1(var_q[4]) + choose(var_q[4], var_q[5], var_q[6])
		+ RoundK[rnd_q] + w_t;
	assign t2      = big_sig0(var_q[0]) + major(var_q[0], var_q[1], var_q[2]);

	// schedule window and working variables
	always_ff @(posedge clk) begin
		if (state_q == ST_PRIME) begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= hash_q[i];
			end
		end
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < BlkWrds - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BlkWrds-1] <= w_t;
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
		if (feed) begin
			part_q <= {part_q[15:0], feed_byte};
		end
	end

	// control sequencer, counters and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pos_q   <= '0;
			count_q <= '0;
			first_q <= 1'b0;
			len_q   <= 1'b0;
			pad_q   <= 1'b0;
			done_q  <= 1'b0;
			rnd_q   <= '0;
			idx_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= InitHash[i];
			end
		end else begin
			if (feed) begin
				pos_q <= pos_q + 1'b1;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (byte_valid) begin
							count_q <= count_q + 1'b1;
						end
						if (end_of_message) begin
							first_q <= 1'b1;
							pad_q   <= 1'b1;
						end
						priority if (byte_valid && pos_q == 6'd63) begin
							state_q <= ST_PRIME;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (len_now) begin
						len_q <= 1'b1;
					end
					if (pos_q == 6'd63) begin
						done_q  <= len_now;
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + var_q[i];
					end
					priority if (done_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) begin
								hash_q[i] <= InitHash[i];
							end
							count_q <= '0;
							len_q   <= 1'b0;
							pad_q   <= 1'b0;
							done_q  <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// digest word output
	assign digest_word = hash_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	// block ram is written only while bytes or padding flow in
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_LOAD || state_q == ST_PAD))
		else $error("block ram written during compression");

	// last round is always followed by the hash add
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_ADD))
		else $error("round sequence did not end in hash add");

	// a finished digest leaves the byte counter and block position cleared
	a_digest_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> (count_q == '0 && pos_q == '0 && state_q == ST_LOAD))
		else $error("state not cleared after digest");

	// compression starts only at a block boundary
	a_prime_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRIME) |-> (pos_q == '0))
		else $error("compression started off a block boundary");

endmodule
